/* rtl/note_notation_tone_decoder_assert.svh */
// Assertion macros for the note notation tone decoder.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef NOTE_NOTATION_TONE_DECODER_ASSERT_SVH
`define NOTE_NOTATION_TONE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ntd_pkg.sv */
package ntd_pkg;

  // Fractional bits of the semitone table as used by the frequency datapath.
  localparam int FRAC_BITS = 24;
  localparam int TAB_W     = FRAC_BITS + 1;
  // 55 * 2^(k/12) stays below 128, so seven integer bits are enough.
  localparam int PROD_W    = FRAC_BITS + 7;
  localparam int SH_W      = $clog2(FRAC_BITS + 3);

  localparam int BPM_W     = 10;
  localparam int LEN_W     = 8;
  localparam int DIVISOR_W = BPM_W + LEN_W;
  localparam int QUO_W     = 18;
  localparam int CNT_W     = $clog2(QUO_W + 1);
  localparam logic [QUO_W-1:0] MS_DIVIDEND = 18'd240000;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // 2^(k/12) for k = 0..11 with 24 fractional bits.
  localparam logic [24:0] SEMITONE_TAB24 [0:11] = '{
    25'd16777216, 25'd17774841, 25'd18831788, 25'd19951585,
    25'd21137968, 25'd22394897, 25'd23726566, 25'd25137421,
    25'd26632170, 25'd28215802, 25'd29893600, 25'd31671166
  };

  // Note letters in semitone order, C first.
  localparam logic [7:0] LETTER_SET [0:11] = '{
    8'h43, 8'h64, 8'h44, 8'h65, 8'h45, 8'h46,
    8'h67, 8'h47, 8'h61, 8'h41, 8'h42, 8'h48
  };

  typedef enum logic [2:0] {
    PH_TEMPO0  = 3'd0,
    PH_TEMPO1  = 3'd1,
    PH_TEMPO2  = 3'd2,
    PH_HDR_SEP = 3'd3,
    PH_LETTER  = 3'd4,
    PH_OCTAVE  = 3'd5,
    PH_LENGTH  = 3'd6,
    PH_TOK_SEP = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_MUL  = 2'd1,
    SEQ_DIV  = 2'd2,
    SEQ_DONE = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic [BPM_W-1:0] bpm;
    logic [7:0]       letter;
    logic [3:0]       octave;
    logic             octave_bad;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] b);
    logic [7:0] d;
    d = b - CH_ZERO;
    return is_digit(b) ? d[3:0] : 4'd0;
  endfunction

  // Length divisor: '0'..'9' give 1..10, letters from 'A' on continue at 11.
  // Bytes below '0' are flagged elsewhere and return zero here.
  function automatic logic [LEN_W-1:0] len_value(input logic [7:0] b);
    logic [7:0] v;
    v = b - 8'd47;
    if (v > 8'd10) begin
      v = v - 8'd7;
    end
    if (b < CH_ZERO) begin
      v = 8'd0;
    end
    return LEN_W'(v);
  endfunction

  // Semitone index 1..12, zero when the byte is not a note letter.
  function automatic logic [3:0] letter_index(input logic [7:0] b);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (b == LETTER_SET[i]) begin
        idx = 4'(i + 1);
      end
    end
    return idx;
  endfunction

  // Table entry aligned from 24 fractional bits to FRAC_BITS.
  function automatic logic [TAB_W-1:0] table_entry(input logic [3:0] k);
    logic [63:0] t;
    logic [63:0] v;
    t = 64'd0;
    if (k < 4'd12) begin
      t = 64'(SEMITONE_TAB24[k]);
    end
    if (FRAC_BITS >= 24) begin
      v = t << (FRAC_BITS - 24);
    end else begin
      v = (t + (64'd1 << (23 - FRAC_BITS))) >> (24 - FRAC_BITS);
    end
    return v[TAB_W-1:0];
  endfunction

endpackage

/* rtl/ntd_parser.sv */
module ntd_parser import ntd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] stream_byte,
  output phase_t     phase,
  output tok_t       tok
);

  phase_t     phase_next;
  logic [3:0] dig;

  assign dig = digit_value(stream_byte);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_TEMPO0:  phase_next = PH_TEMPO1;
        PH_TEMPO1:  phase_next = PH_TEMPO2;
        PH_TEMPO2:  phase_next = PH_HDR_SEP;
        PH_HDR_SEP: phase_next = PH_LETTER;
        PH_LETTER:  phase_next = PH_OCTAVE;
        PH_OCTAVE:  phase_next = PH_LENGTH;
        PH_LENGTH:  phase_next = PH_TOK_SEP;
        PH_TOK_SEP: phase_next = PH_LETTER;
        default:    phase_next = PH_TEMPO0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEMPO0;
      tok   <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        case (phase)
          PH_TEMPO0: tok.bpm <= 10'd100 * BPM_W'(dig);
          PH_TEMPO1: tok.bpm <= tok.bpm + 10'd10 * BPM_W'(dig);
          PH_TEMPO2: tok.bpm <= tok.bpm + BPM_W'(dig);
          PH_LETTER: tok.letter <= stream_byte;
          PH_OCTAVE: begin
            tok.octave_bad <= !is_digit(stream_byte);
            tok.octave     <= dig;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/ntd_freq.sv */
module ntd_freq import ntd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [3:0]  idx,
  input  logic [3:0]  octave,
  input  logic        silent,
  output logic [15:0] freq
);

  logic [3:0]        m;
  logic [3:0]        k;
  logic [3:0]        q;
  logic              carry;
  logic [PROD_W-1:0] prod;
  logic [3:0]        q_r;
  logic              silent_r;
  logic [SH_W-1:0]   sh;
  logic [PROD_W:0]   rounded;
  logic [PROD_W:0]   shifted;

  // n = 12*octave + idx + 2 split into a semitone and an octave carry.
  assign m     = idx + 4'd2;
  assign carry = (m >= 4'd12);
  assign k     = carry ? m - 4'd12 : m;
  assign q     = octave + {3'd0, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      silent_r <= 1'b1;
    end else if (start) begin
      silent_r <= silent;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(55) * PROD_W'(table_entry(k));
      q_r  <= q;
    end
  end

  // Second step: rounding right shift by FRAC_BITS + 2 - q.
  assign sh      = SH_W'(FRAC_BITS + 2) - SH_W'(q_r);
  assign rounded = {1'b0, prod} + ((PROD_W + 1)'(1) << (sh - SH_W'(1)));
  assign shifted = rounded >> sh;

  always_ff @(posedge clk) begin
    if (silent_r) begin
      freq <= 16'd0;
    end else if (shifted > (PROD_W + 1)'(16'hFFFF)) begin
      freq <= 16'hFFFF;
    end else begin
      freq <= shifted[15:0];
    end
  end

endmodule

/* rtl/ntd_div.sv */
module ntd_div import ntd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [15:0]          quotient
);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [QUO_W-1:0]     quo;
  logic [QUO_W-1:0]     dvd;
  logic [DIVISOR_W-1:0] div_reg;
  logic                 round_step;
  logic [DIVISOR_W:0]   a;
  logic [DIVISOR_W+1:0] diff;
  logic                 ge;
  logic                 eq;
  logic                 up;
  logic [QUO_W-1:0]     quo_rnd;

  assign round_step = (cnt == CNT_W'(QUO_W));

  // One subtractor serves both the restoring steps and the final rounding
  // compare, where it sees twice the remainder.
  assign a    = round_step ? {rem, 1'b0} : {rem, dvd[QUO_W-1]};
  assign diff = {1'b0, a} - {2'b00, div_reg};
  assign ge   = !diff[DIVISOR_W+1];
  assign eq   = (a == {1'b0, div_reg});

  // Round to nearest, ties to even.
  assign up      = (ge && !eq) || (eq && quo[0]);
  assign quo_rnd = quo + QUO_W'(up);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && round_step && !start;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (round_step) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= '0;
      dvd     <= MS_DIVIDEND;
      div_reg <= divisor;
    end else if (busy) begin
      if (round_step) begin
        quotient <= (quo_rnd > QUO_W'(16'hFFFF)) ? 16'hFFFF : quo_rnd[15:0];
      end else begin
        rem <= ge ? diff[DIVISOR_W-1:0] : a[DIVISOR_W-1:0];
        quo <= {quo[QUO_W-2:0], ge};
        dvd <= {dvd[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/note_notation_tone_decoder.sv */
// Note notation tone decoder.
//
// Requests on the input channel (in_valid/in_ready) carry one byte each:
// three tempo digits, a separator, then note tokens of letter, octave digit
// and length character, each followed by a separator. Every length byte
// completes a token and produces one request on the output channel
// (out_valid/out_ready) with frequency, duration, rest and error flags.
// All other bytes are taken back to back while in_ready is high and produce
// nothing. A length byte keeps in_ready low through the tempo-by-length
// product, 18 restoring steps and one rounding step of the shared
// subtract/compare unit in the divider, and the hand-off to the output
// register. The frequency path finishes while the divider is still busy.
// The finished result sits in an output register, so while it waits for
// out_ready the block keeps parsing bytes. The next length byte is still
// taken, but in_ready then stays low until the register is free.
// Reset returns the parser to the first tempo digit, clears tempo and token
// state, drops out_valid and clears the octave shift register, written by
// the user through cfg_we/cfg_data while idle; the block does not check it.
`include "note_notation_tone_decoder_assert.svh"

module note_notation_tone_decoder import ntd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic [7:0]  stream_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [15:0] tone_freq_hz,
  output logic [15:0] tone_ms,
  output logic        is_rest,
  output logic        bad_token,
  output logic        out_valid,
  input  logic        out_ready
);

  seq_state_t       state;
  seq_state_t       state_next;
  phase_t           parse_phase;
  tok_t             tok;
  logic             octave_shift;
  logic             in_accept;
  logic             token_end;
  logic             div_start;
  logic             div_done;
  logic             load;
  logic [15:0]      div_ms;
  logic [15:0]      freq;

  // Token captured at its length byte.
  logic [3:0]       job_idx;
  logic [3:0]       job_oct;
  logic [BPM_W-1:0] job_bpm;
  logic [LEN_W-1:0] job_len;
  logic             job_oct_bad;
  logic             job_dur_bad;

  assign in_accept = in_valid && in_ready;
  assign token_end = in_accept && (parse_phase == PH_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_shift <= 1'b0;
    end else if (cfg_we) begin
      octave_shift <= cfg_data;
    end
  end

  ntd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .stream_byte (stream_byte),
    .phase       (parse_phase),
    .tok         (tok)
  );

  // The octave shift in force at the length byte is the one that applies.
  always_ff @(posedge clk) begin
    if (token_end) begin
      job_idx     <= letter_index(tok.letter);
      job_oct     <= tok.octave + {3'd0, octave_shift};
      job_bpm     <= tok.bpm;
      job_len     <= len_value(stream_byte);
      job_oct_bad <= tok.octave_bad;
      job_dur_bad <= (stream_byte < CH_ZERO) || (tok.bpm == '0);
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: if (token_end) state_next = SEQ_MUL;
      SEQ_MUL:  state_next = SEQ_DIV;
      SEQ_DIV:  if (div_done) state_next = SEQ_DONE;
      SEQ_DONE: if (!out_valid || out_ready) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    case (state)
      SEQ_IDLE: in_ready = 1'b1;
      SEQ_MUL:  div_start = 1'b1;
      SEQ_DONE: load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The divisor goes straight from the product into the divider's register.
  ntd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (DIVISOR_W'(job_bpm) * DIVISOR_W'(job_len)),
    .done     (div_done),
    .quotient (div_ms)
  );

  // A rest or an unreadable octave gives a silent tone.
  ntd_freq u_freq (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .idx    (job_idx),
    .octave (job_oct),
    .silent ((job_idx == 4'd0) || job_oct_bad),
    .freq   (freq)
  );

  // Output register; it frees the parser while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tone_freq_hz <= freq;
      tone_ms      <= job_dur_bad ? 16'd0 : div_ms;
      is_rest      <= (job_idx == 4'd0);
      bad_token    <= job_oct_bad || job_dur_bad;
    end
  end

  `NTD_ASSERT_NOW(a_rest_is_silent, out_valid && is_rest, tone_freq_hz == 16'd0,
    "rest delivered with a nonzero frequency")
  `NTD_ASSERT_NEXT(a_token_starts_job, token_end, (state == SEQ_MUL) && !in_ready,
    "length byte did not start the duration computation")
  `NTD_ASSERT_NOW(a_div_done_in_div, div_done, state == SEQ_DIV,
    "divider finished outside the divide phase")

endmodule

/* bench/note_notation_tone_decoder_tb.sv */
module note_notation_tone_decoder_tb;
  import ntd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The run stops here even if the block hangs. The slowest legal run is at most
  // 2052 bytes, each with the longest send gap, the divider work and the longest
  // output stall, and it stays well below this limit.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Before a register write, and at the end of the run, we wait long enough
  // for the block to finish the work that a length byte starts.
  localparam int HOLD_OFF    = 30;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 4;
  localparam int PHASE_BYTES = 500;

  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_9 = 8'h39;

  // 2^(k/12) for k = 0..11, with 24 fractional bits, rounded to nearest.
  localparam logic [31:0] TONE_STEPS [12] = '{
    32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
    32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
    32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166
  };

  // The twelve note letters in semitone order. Any other letter is a rest.
  localparam logic [7:0] NOTE_CHARS [12] = '{
    "C", "d", "D", "e", "E", "F", "g", "G", "a", "A", "B", "H"
  };

  typedef struct packed {
    logic [15:0] freq_hz;
    logic [15:0] ms;
    logic        rest;
    logic        bad;
  } tone_t;

  typedef struct packed {
    logic [7:0] data;
    logic       checked;
    tone_t      tone;
  } stim_row_t;

  localparam tone_t NO_TONE  = '0;
  localparam tone_t REST_BAD = '{16'd0, 16'd0, 1'b1, 1'b1};

  // Directed tokens, sent right after the tempo header. A row with checked
  // set carries a hand-written result. Every other length byte is predicted.
  localparam int DIR_ROWS = 20;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // Unknown letter, non-digit octave and a length byte below '0'. Every
    // error shows at once.
    '{"x",   1'b0, NO_TONE}, '{"z", 1'b0, NO_TONE}, '{"!", 1'b1, REST_BAD},
    '{" ",   1'b0, NO_TONE},
    // Letter byte zero is a rest. Length '/' gives divisor zero.
    '{8'h00, 1'b0, NO_TONE}, '{"0", 1'b0, NO_TONE}, '{"/", 1'b1, REST_BAD},
    '{8'h00, 1'b0, NO_TONE},
    // Lowest note at the lowest octave digit, with length '1' (divisor twice the tempo).
    '{"C",   1'b0, NO_TONE}, '{"0", 1'b0, NO_TONE}, '{"1", 1'b0, NO_TONE},
    '{8'hFF, 1'b0, NO_TONE},
    // Highest note at the highest octave, with the largest divisor (201).
    '{"H",   1'b0, NO_TONE}, '{"9", 1'b0, NO_TONE}, '{8'hFF, 1'b0, NO_TONE},
    '{8'h80, 1'b0, NO_TONE},
    // A valid letter with a bad octave byte: no frequency, but a duration unless the tempo is zero.
    '{"g",   1'b0, NO_TONE}, '{8'hFF, 1'b0, NO_TONE}, '{"Z", 1'b0, NO_TONE},
    '{8'h7F, 1'b0, NO_TONE}
  };

  // Every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic [7:0]  stream_byte = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] tone_freq_hz;
  logic [15:0] tone_ms;
  logic        is_rest;
  logic        bad_token;
  logic        out_valid;
  logic        out_ready = 1'b0;

  // This is our own copy of the parser and the octave shift register. It is
  // updated on every request that the block accepts.
  phase_t      cur_phase    = PH_TEMPO0;
  logic [9:0]  bpm          = '0;
  logic [7:0]  held_letter  = '0;
  logic [3:0]  held_oct     = '0;
  logic        held_oct_bad = 1'b0;
  logic        octave_up    = 1'b0;

  tone_t pending_tones [$];
  int    mismatches  = 0;
  int    cycle_count = 0;
  int    ready_hold  = 0;
  // When quiet is set, neither side idles. This gives back-to-back stretches.
  bit    quiet       = 1'b0;

  note_notation_tone_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .stream_byte  (stream_byte),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tone_freq_hz (tone_freq_hz),
    .tone_ms      (tone_ms),
    .is_rest      (is_rest),
    .bad_token    (bad_token),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Most gaps are zero or short. A few are long enough to let the divider
  // finish while the other side waits.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(30, 80);
  endfunction

  // This advances the parser by one byte. It returns 1 when the byte is a
  // length byte, which completes a tone. The tone is returned in t.
  function automatic bit decode_byte(input logic [7:0] b, output tone_t t);
    logic [3:0]  dig;
    bit          is_dig;
    int          idx, n, q, k, s, len, d, qt, r;
    logic [63:0] prod, f;
    is_dig = (b >= ASCII_0) && (b <= ASCII_9);
    dig = is_dig ? 4'(b - ASCII_0) : 4'd0;
    t = NO_TONE;
    case (cur_phase)
      PH_TEMPO0: begin
        bpm = 10'(100 * dig);
        cur_phase = PH_TEMPO1;
      end
      PH_TEMPO1: begin
        bpm = 10'(bpm + 10 * dig);
        cur_phase = PH_TEMPO2;
      end
      PH_TEMPO2: begin
        bpm = 10'(bpm + dig);
        cur_phase = PH_HDR_SEP;
      end
      PH_HDR_SEP, PH_TOK_SEP: begin
        cur_phase = PH_LETTER;
      end
      PH_LETTER: begin
        held_letter = b;
        cur_phase = PH_OCTAVE;
      end
      PH_OCTAVE: begin
        held_oct_bad = !is_dig;
        held_oct = dig;
        cur_phase = PH_LENGTH;
      end
      default: begin
        cur_phase = PH_TOK_SEP;
        idx = 0;
        for (int i = 0; i < 12; i++) begin
          if (held_letter != 8'h00 && held_letter == NOTE_CHARS[i]) begin
            idx = i + 1;
          end
        end
        t.rest = (idx == 0);
        if (held_oct_bad) begin
          t.bad = 1'b1;
        end else if (idx != 0) begin
          // Count semitones from two below the table base. Then split the
          // count into a power of two and a table step, and round half up.
          n = 12 * (held_oct + octave_up) + idx + 2;
          q = n / 12;
          k = n % 12;
          prod = 64'd55 * 64'(TONE_STEPS[k]);
          s = 26 - q;
          f = (prod + (64'd1 << (s - 1))) >> s;
          t.freq_hz = (f > 64'd65535) ? 16'hFFFF : f[15:0];
        end
        // Digits give divisors 1..10, and bytes from ':' on start over at 4.
        len = int'(b) - 47;
        if (len > 10) len -= 7;
        if (len < 1 || bpm == 10'd0) begin
          t.bad = 1'b1;
        end else begin
          d = int'(bpm) * len;
          qt = 240000 / d;
          r = 240000 % d;
          // Round to nearest. A tie goes to the even quotient.
          if (2 * r > d || (2 * r == d && qt % 2 == 1)) qt++;
          t.ms = (qt > 65535) ? 16'hFFFF : 16'(qt);
        end
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // This picks the next random byte to suit the field that the parser
  // expects. Most tokens are well formed. Some carry a stray letter, octave
  // or length byte.
  function automatic logic [7:0] next_stream_byte();
    int r;
    r = $urandom_range(0, 99);
    case (cur_phase)
      PH_LETTER: begin
        if (r < 85) return NOTE_CHARS[$urandom_range(0, 11)];
      end
      PH_OCTAVE: begin
        if (r < 88) return 8'(ASCII_0 + $urandom_range(0, 9));
      end
      PH_LENGTH: begin
        if (r < 30) return 8'(ASCII_0 + $urandom_range(0, 9));
        if (r < 55) return 8'($urandom_range(8'h41, 8'h5A));
        if (r < 70) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 80) return 8'($urandom_range(8'h3A, 8'h40));
      end
      default: ;
    endcase
    return 8'($urandom_range(0, 255));
  endfunction

  // This sends one byte request. Inputs change only on falling edges. The
  // byte is accepted on the first rising edge at which in_ready is high.
  // A checked row replaces the predicted tone with the hand-written one.
  // The predictor still runs, so that its state stays in step.
  task automatic send_byte(input logic [7:0] b, input logic checked,
                           input tone_t typed_tone);
    tone_t t;
    int    gap;
    gap = quiet ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (decode_byte(b, t)) begin
      pending_tones.push_back(checked ? typed_tone : t);
    end
  endtask

  // The sender stops first and waits until every expected tone has arrived.
  // It then gives the divider time to go idle, and writes the octave shift.
  // The parser may be in the middle of a token. The new value applies to
  // the next length byte.
  task automatic set_octave_shift(input logic value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    octave_up = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The result side also stalls at random, except in quiet stretches.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) ready_hold = idle_len();
    end
  end

  // Each accepted result is checked against the oldest expected tone.
  always @(posedge clk) begin : check_tones
    tone_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_tones.size() == 0) begin
        $error("unexpected result: tone_freq_hz %0d tone_ms %0d is_rest %0b bad_token %0b",
               tone_freq_hz, tone_ms, is_rest, bad_token);
        mismatches++;
      end else begin
        want = pending_tones.pop_front();
        if (tone_freq_hz !== want.freq_hz) begin
          $error("tone_freq_hz: expected %0d, got %0d", want.freq_hz, tone_freq_hz);
          mismatches++;
        end
        if (tone_ms !== want.ms) begin
          $error("tone_ms: expected %0d, got %0d", want.ms, tone_ms);
          mismatches++;
        end
        if (is_rest !== want.rest) begin
          $error("is_rest: expected %0b, got %0b", want.rest, is_rest);
          mismatches++;
        end
        if (bad_token !== want.bad) begin
          $error("bad_token: expected %0b, got %0b", want.bad, bad_token);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int         tempo;
    int         dg;
    int         nbytes;
    logic [7:0] hb;
    logic       shift_val;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The directed tokens run with the shift set. The high octave then
    // reaches ten.
    set_octave_shift(1'b1);

    // The tempo header is parsed once per reset, so one tempo covers the whole
    // run. The simulator seed picks its class: sometimes zero, sometimes small
    // enough to saturate the duration, sometimes a power of two that gives
    // exact ties. Zero digits are often replaced by non-digit bytes, which
    // must count as zero.
    tempo = $urandom_range(0, 15);
    case (tempo)
      0:       tempo = 0;
      1, 2:    tempo = $urandom_range(1, 3);
      3, 4:    tempo = 16 << $urandom_range(0, 3);
      5:       tempo = 999;
      default: tempo = $urandom_range(1, 999);
    endcase
    for (int p = 0; p < 3; p++) begin
      dg = (p == 0) ? tempo / 100 : (p == 1) ? (tempo / 10) % 10 : tempo % 10;
      if (dg == 0 && $urandom_range(0, 1) == 1) begin
        hb = $urandom_range(0, 1) ? 8'($urandom_range(0, 47))
                                  : 8'($urandom_range(58, 255));
      end else begin
        hb = 8'(ASCII_0 + dg);
      end
      send_byte(hb, 1'b0, NO_TONE);
    end
    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_TONE);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_byte(DIRECTED[r].data, DIRECTED[r].checked, DIRECTED[r].tone);
    end

    // Random phases, each with its own shift setting. Both values come up
    // at least once. A phase ends at an arbitrary byte, so register writes
    // also land in the middle of a token.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      shift_val = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      set_octave_shift(shift_val);
      nbytes = PHASE_BYTES + $urandom_range(0, 7);
      for (int i = 0; i < nbytes; i++) begin
        if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_byte(next_stream_byte(), 1'b0, NO_TONE);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tones.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ntd_pkg.sv
rtl/ntd_parser.sv
rtl/ntd_freq.sv
rtl/ntd_div.sv
rtl/note_notation_tone_decoder.sv
bench/note_notation_tone_decoder_tb.sv
